@@ design/dgpio_pkg.sv @@
// ----------------------------------------------------------------------------
// dgpio_pkg: shared types and constants
// Register addresses, command codes and the queue entry of the GPIO block.
// ----------------------------------------------------------------------------
package dgpio_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   localparam logic [7:0] A_OUT0 = 8'd0;
   localparam logic [7:0] A_OUT1 = 8'd1;
   localparam logic [7:0] A_DIR0 = 8'd2;
   localparam logic [7:0] A_DIR1 = 8'd3;
   localparam logic [7:0] A_CTRL = 8'd4;
   localparam logic [7:0] A_STAT = 8'd5;
   localparam logic [7:0] A_ID   = 8'd6;
   localparam logic [7:0] A_DEB  = 8'd7;
   localparam logic [7:0] A_IEN  = 8'd8;
   localparam logic [7:0] A_IST  = 8'd9;
   localparam logic [7:0] A_CLR0 = 8'd10;
   localparam logic [7:0] A_CLR1 = 8'd11;
   localparam logic [7:0] A_RAW0 = 8'd12;
   localparam logic [7:0] A_RAW1 = 8'd13;
   localparam logic [7:0] A_STB0 = 8'd14;
   localparam logic [7:0] A_STB1 = 8'd15;
   localparam logic [7:0] A_CNT  = 8'd16;
   localparam logic [8:0] A_CNT_END = 9'd48;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam logic [7:0]  DEB_RESET = 8'd20;

   // classified request handed from front to back
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  address;
      logic [7:0]  write_data;
      logic [7:0]  pins0;
      logic [7:0]  pins1;
      logic        ok0;
      logic        ok1;
      logic [31:0] now_ms;
   } entry_type;

endpackage

@@ design/dgpio_if.sv @@
// ----------------------------------------------------------------------------
// dgpio channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface dgpio_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  address;
   logic [7:0]  write_data;
   logic [7:0]  pins_bank0;
   logic [7:0]  pins_bank1;
   logic        bank0_ok;
   logic        bank1_ok;
   logic [31:0] now_ms;
   modport source (output valid, command, address, write_data, pins_bank0,
                   pins_bank1, bank0_ok, bank1_ok, now_ms, input ready);
   modport sink (input valid, command, address, write_data, pins_bank0,
                 pins_bank1, bank0_ok, bank1_ok, now_ms, output ready);
endinterface

interface dgpio_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq;
   logic [7:0] drive_out0;
   logic [7:0] drive_out1;
   logic [7:0] drive_dir0;
   logic [7:0] drive_dir1;
   logic       drive_enable;
   modport source (output valid, read_data, irq, drive_out0, drive_out1,
                   drive_dir0, drive_dir1, drive_enable, input ready);
   modport sink (input valid, read_data, irq, drive_out0, drive_out1,
                 drive_dir0, drive_dir1, drive_enable, output ready);
endinterface

@@ design/dgpio_front.sv @@
// ----------------------------------------------------------------------------
// dgpio_front: request intake
// Classifies each request and registers it into a two-entry queue.
// ----------------------------------------------------------------------------
module dgpio_front (
   input  logic                 clock,
   input  logic                 reset,
   dgpio_req_if.sink            req,
   output dgpio_pkg::entry_type q_data,
   output logic                 q_valid,
   input  logic                 q_pop
);

   dgpio_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   dgpio_pkg::entry_type incoming;

   // classify the incoming request
   always_comb begin
      incoming.cmd        = dgpio_pkg::cmd_type'(req.command);
      incoming.address    = req.address;
      incoming.write_data = req.write_data;
      incoming.pins0      = req.pins_bank0;
      incoming.pins1      = req.pins_bank1;
      incoming.ok0        = req.bank0_ok;
      incoming.ok1        = req.bank1_ok;
      incoming.now_ms     = req.now_ms;
   end

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= incoming;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !req.ready) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("bad queue count");
`endif

endmodule

@@ design/dgpio_back.sv @@
// ----------------------------------------------------------------------------
// dgpio_back: register file and debounce engine
// Executes queued requests into a response register, one per cycle unless a response waits to be taken.
// ----------------------------------------------------------------------------
module dgpio_back #(
   parameter logic [7:0] DEVICE_ID = 8'd90,
   parameter int         REG_SPACE = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dgpio_pkg::entry_type q_data,
   input  logic                 q_valid,
   output logic                 q_pop,
   dgpio_rsp_if.source          rsp
);

   logic [7:0]  out_ff [2];
   logic [7:0]  out_in [2];
   logic [7:0]  dir_ff [2];
   logic [7:0]  dir_in [2];
   logic        en_ff, en_in;
   logic [1:0]  ien_ff, ien_in;
   logic [1:0]  ist_ff, ist_in;
   logic [7:0]  deb_ff, deb_in;
   logic [7:0]  stb_ff [2];
   logic [7:0]  stb_in [2];
   logic [7:0]  raw_ff [2];
   logic [7:0]  raw_in [2];
   logic [7:0]  cand_ff [2];
   logic [7:0]  cand_in [2];
   logic [31:0] ct_ff [16];
   logic [31:0] ct_in [16];
   logic [15:0] cnt_ff [16];
   logic [15:0] cnt_in [16];
   logic [1:0]  base_ff, base_in;
   logic [1:0]  chg_ff, chg_in;
   logic        err_ff, err_in;

   logic        rvalid_ff, rvalid_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        fire;
   logic [7:0]  rd;
   logic        pend;
   logic [3:0]  pin_sel;
   logic [7:0]  pins [2];
   logic        oks [2];
   logic [31:0] age;

   assign q_pop = q_valid && (!rvalid_ff || rsp.ready);
   assign fire  = q_pop;
   assign pend  = en_ff && ((ist_ff & ien_ff) != 2'b00);
   assign pins[0] = q_data.pins0;
   assign pins[1] = q_data.pins1;
   assign oks[0]  = q_data.ok0;
   assign oks[1]  = q_data.ok1;
   assign pin_sel = 4'((q_data.address - dgpio_pkg::A_CNT) >> 1);

   // register read mux
   always_comb begin
      rd = 8'd0;
      if ({1'b0, q_data.address} < 9'(REG_SPACE) &&
          {1'b0, q_data.address} < dgpio_pkg::A_CNT_END) begin
         if (q_data.address >= dgpio_pkg::A_CNT) begin
            rd = q_data.address[0] ? cnt_ff[pin_sel][15:8]
                                   : cnt_ff[pin_sel][7:0];
         end else begin
            unique case (q_data.address)
               dgpio_pkg::A_OUT0: rd = out_ff[0];
               dgpio_pkg::A_OUT1: rd = out_ff[1];
               dgpio_pkg::A_DIR0: rd = dir_ff[0];
               dgpio_pkg::A_DIR1: rd = dir_ff[1];
               dgpio_pkg::A_CTRL: rd = {7'd0, en_ff};
               dgpio_pkg::A_STAT: rd = {5'd0, pend, err_ff, en_ff};
               dgpio_pkg::A_ID:   rd = DEVICE_ID;
               dgpio_pkg::A_DEB:  rd = deb_ff;
               dgpio_pkg::A_IEN:  rd = {6'd0, ien_ff};
               dgpio_pkg::A_IST:  rd = {6'd0, ist_ff};
               dgpio_pkg::A_RAW0: rd = raw_ff[0];
               dgpio_pkg::A_RAW1: rd = raw_ff[1];
               dgpio_pkg::A_STB0: rd = stb_ff[0];
               dgpio_pkg::A_STB1: rd = stb_ff[1];
               default:           rd = 8'd0;
            endcase
         end
      end
   end

   // request execution
   always_comb begin
      out_in  = out_ff;
      dir_in  = dir_ff;
      en_in   = en_ff;
      ien_in  = ien_ff;
      ist_in  = ist_ff;
      deb_in  = deb_ff;
      stb_in  = stb_ff;
      raw_in  = raw_ff;
      cand_in = cand_ff;
      ct_in   = ct_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      chg_in  = chg_ff;
      err_in  = err_ff;
      rdata_in = rdata_ff;
      age = 32'd0;
      if (fire) begin
         rdata_in = 8'd0;
         case (q_data.cmd)
            dgpio_pkg::CMD_WRITE: begin
               unique case (q_data.address)
                  dgpio_pkg::A_OUT0: out_in[0] = q_data.write_data;
                  dgpio_pkg::A_OUT1: out_in[1] = q_data.write_data;
                  dgpio_pkg::A_DIR0: begin
                     if (dir_ff[0] != q_data.write_data) chg_in = 2'b11;
                     dir_in[0] = q_data.write_data;
                  end
                  dgpio_pkg::A_DIR1: begin
                     if (dir_ff[1] != q_data.write_data) chg_in = 2'b11;
                     dir_in[1] = q_data.write_data;
                  end
                  dgpio_pkg::A_DEB: begin
                     if (deb_ff != q_data.write_data) chg_in = 2'b11;
                     deb_in = q_data.write_data;
                  end
                  dgpio_pkg::A_CTRL: begin
                     if (en_ff != q_data.write_data[0]) chg_in = 2'b11;
                     en_in = q_data.write_data[0];
                     if (!q_data.write_data[0]) ist_in = 2'b00;
                  end
                  dgpio_pkg::A_IEN: ien_in = q_data.write_data[1:0];
                  dgpio_pkg::A_IST: ist_in = ist_ff & ~q_data.write_data[1:0];
                  dgpio_pkg::A_CLR0: begin
                     for (int b = 0; b < 8; b++)
                        if (q_data.write_data[b]) cnt_in[b] = 16'd0;
                  end
                  dgpio_pkg::A_CLR1: begin
                     for (int b = 0; b < 8; b++)
                        if (q_data.write_data[b]) cnt_in[8 + b] = 16'd0;
                  end
                  default: ;
               endcase
            end
            dgpio_pkg::CMD_READ: rdata_in = rd;
            dgpio_pkg::CMD_SAMPLE: begin
               err_in = !(oks[0] && oks[1]);
               for (int k = 0; k < 2; k++) begin
                  if (!oks[k]) begin
                     base_in[k] = 1'b0;
                  end else begin
                     raw_in[k] = pins[k];
                     if (!en_ff || !base_ff[k] || chg_ff[k]) begin
                        cand_in[k] = pins[k];
                        stb_in[k]  = pins[k];
                        for (int b = 0; b < 8; b++) ct_in[k * 8 + b] = q_data.now_ms;
                     end else begin
                        for (int b = 0; b < 8; b++) begin
                           // a pin that just moved off its candidate restarts its timer
                           if (pins[k][b] != cand_ff[k][b]) begin
                              cand_in[k][b] = pins[k][b];
                              ct_in[k * 8 + b] = q_data.now_ms;
                              age = 32'd0;
                           end else begin
                              age = q_data.now_ms - ct_ff[k * 8 + b];
                           end
                           if (stb_ff[k][b] != pins[k][b]) begin
                              if (!dir_ff[k][b]) begin
                                 stb_in[k][b] = pins[k][b];
                              end else if (age >= {24'd0, deb_ff}) begin
                                 stb_in[k][b] = pins[k][b];
                                 ist_in[k] = 1'b1;
                                 if (cnt_ff[k * 8 + b] != dgpio_pkg::CNT_MAX)
                                    cnt_in[k * 8 + b] = cnt_ff[k * 8 + b] + 16'd1;
                              end
                           end
                        end
                     end
                     base_in[k] = en_ff;
                     chg_in[k]  = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
      rvalid_in = fire || (rvalid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff    <= '{8'd0, 8'd0};
         dir_ff    <= '{8'hFF, 8'hFF};
         en_ff     <= 1'b1;
         ien_ff    <= 2'b00;
         ist_ff    <= 2'b00;
         deb_ff    <= dgpio_pkg::DEB_RESET;
         stb_ff    <= '{8'd0, 8'd0};
         raw_ff    <= '{8'd0, 8'd0};
         cand_ff   <= '{8'd0, 8'd0};
         ct_ff     <= '{default: 32'd0};
         cnt_ff    <= '{default: 16'd0};
         base_ff   <= 2'b00;
         chg_ff    <= 2'b11;
         err_ff    <= 1'b1;
         rvalid_ff <= 1'b0;
      end else begin
         out_ff    <= out_in;
         dir_ff    <= dir_in;
         en_ff     <= en_in;
         ien_ff    <= ien_in;
         ist_ff    <= ist_in;
         deb_ff    <= deb_in;
         stb_ff    <= stb_in;
         raw_ff    <= raw_in;
         cand_ff   <= cand_in;
         ct_ff     <= ct_in;
         cnt_ff    <= cnt_in;
         base_ff   <= base_in;
         chg_ff    <= chg_in;
         err_ff    <= err_in;
         rvalid_ff <= rvalid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      rdata_ff <= rdata_in;
   end

   assign rsp.valid        = rvalid_ff;
   assign rsp.read_data    = rdata_ff;
   assign rsp.irq          = pend;
   assign rsp.drive_out0   = out_ff[0];
   assign rsp.drive_out1   = out_ff[1];
   assign rsp.drive_dir0   = dir_ff[0];
   assign rsp.drive_dir1   = dir_ff[1];
   assign rsp.drive_enable = en_ff;

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp.ready |=> rvalid_ff) else $error("response dropped");
   a_dis_irq: assert property (@(posedge clock) disable iff (reset)
      !en_ff |-> ist_ff == 2'b00) else $error("status set while disabled");
   a_pop_gate: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp.ready |-> !q_pop) else $error("pop while stalled");
`endif

endmodule

@@ design/debounced_gpio_register_block.sv @@
// ----------------------------------------------------------------------------
// debounced_gpio_register_block: two-bank debounced GPIO with event counters
// Top level joining the request intake and the execution engine.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req_ channel (valid/ready); each one is a
// register write, a register read, a pin sample tick or a no-op. Every request gives
// exactly one response on the rsp_ channel with the read byte, the irq line
// and the current drive outputs as they stand after that request.
// Path: a request is written into the two-entry queue when it is accepted,
// executed from the queue head into the response register, and its response
// is then held on the rsp_ channel until it is taken.
// Throughput: one request per cycle while responses are taken, with all
// sixteen pins handled in parallel in the back end.
// Stall: when the response is not taken, it holds; the queue fills up to its
// two entries before req_ready drops.
// Reset: synchronous; all pins inputs, port enabled, debounce 20 ms,
// counters zero, error flag set until the first good sample.
// ----------------------------------------------------------------------------
module debounced_gpio_register_block #(
   parameter logic [7:0] DEVICE_ID = 8'd90,
   parameter int         REG_SPACE = 48
) (
   input  logic clock,
   input  logic reset,
   dgpio_req_if.sink   req,
   dgpio_rsp_if.source rsp
);

   dgpio_pkg::entry_type q_data;
   logic q_valid;
   logic q_pop;

   dgpio_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_data (q_data),
      .q_valid(q_valid),
      .q_pop  (q_pop)
   );

   dgpio_back #(
      .DEVICE_ID(DEVICE_ID),
      .REG_SPACE(REG_SPACE)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_data (q_data),
      .q_valid(q_valid),
      .q_pop  (q_pop),
      .rsp    (rsp)
   );

endmodule
